>>> rtl/jacm_pkg.sv
// ----------------------------------------------------------------------------
// jacm_pkg: shared definitions for the joystick axis calibrated map
// Register indexes, reset values, fixed field widths and the result flags.
// ----------------------------------------------------------------------------
package jacm_pkg;

    localparam int CAL_W       = 36;
    localparam int CAL_REGS    = 4;
    localparam int AXIS_W      = 2;
    localparam int OUT_W       = 16;
    localparam int DB_W        = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_TDATA_W = 24;
    localparam int Q_DEPTH     = 4;

    localparam logic [CAL_W-1:0]        CAL_RESET        = 36'hFFF800000;
    localparam logic [DB_W-1:0]         DEAD_BAND_RESET  = 12'd100;
    localparam logic signed [OUT_W-1:0] OUT_MIN_RESET    = 16'sd0;
    localparam logic signed [OUT_W-1:0] OUT_CENTER_RESET = 16'sd128;
    localparam logic signed [OUT_W-1:0] OUT_MAX_RESET    = 16'sd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_LEFT_X  = 3'd0,
        REG_CAL_LEFT_Y  = 3'd1,
        REG_CAL_RIGHT_X = 3'd2,
        REG_CAL_RIGHT_Y = 3'd3,
        REG_DEAD_BAND   = 3'd4,
        REG_OUT_MIN     = 3'd5,
        REG_OUT_CENTER  = 3'd6,
        REG_OUT_MAX     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic cal_fault;
        logic in_dead_band;
    } flags_t;

endpackage

>>> rtl/jacm_front.sv
// ----------------------------------------------------------------------------
// jacm_front: sample classification and mapping operands
// Looks up the axis calibration, applies the dead band, picks the half-range,
// clamps the sample and forms the product and divisor for the back end.
// ----------------------------------------------------------------------------
module jacm_front #(
    parameter int SAMPLE_BITS = 12,
    parameter int CAL_N       = 4
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [jacm_pkg::AXIS_W-1:0]             in_axis,
    input  logic [SAMPLE_BITS-1:0]                  in_sample,
    input  logic [CAL_N*jacm_pkg::CAL_W-1:0]        cal_bus,
    input  logic [jacm_pkg::DB_W-1:0]               dead_band,
    input  logic signed [jacm_pkg::OUT_W-1:0]       out_min,
    input  logic signed [jacm_pkg::OUT_W-1:0]       out_center,
    input  logic signed [jacm_pkg::OUT_W-1:0]       out_max,
    output logic                                    push_valid,
    input  logic                                    push_ready,
    output logic [2*SAMPLE_BITS+37:0]               push_data
);

    localparam int S         = SAMPLE_BITS;
    localparam int CAL_IDX_W = (CAL_N > 1) ? $clog2(CAL_N) : 1;
    localparam int EXT_W     = (3*S > jacm_pkg::CAL_W) ? 3*S : jacm_pkg::CAL_W;
    localparam int CMP_W     = (S + 1 > jacm_pkg::DB_W) ? S + 1 : jacm_pkg::DB_W;
    localparam int PW        = S + 17;
    localparam int OW        = jacm_pkg::OUT_W;

    logic                    en;
    logic [CAL_IDX_W-1:0]    idx;
    logic [jacm_pkg::CAL_W-1:0] cal_sel;
    logic [EXT_W-1:0]        cal_ext;

    // Stage A: registered sample and selected calibration
    logic                    a_valid_reg;
    logic [jacm_pkg::AXIS_W-1:0] a_axis_reg;
    logic [S-1:0]            a_s_reg;
    logic [S-1:0]            a_min_reg;
    logic [S-1:0]            a_ctr_reg;
    logic [S-1:0]            a_max_reg;

    // Stage B: operands for the multiply and divide
    logic                    b_valid_reg;
    logic [jacm_pkg::AXIS_W-1:0] b_axis_reg;
    jacm_pkg::flags_t        b_flags_reg;
    jacm_pkg::flags_t        b_flags_next;
    logic signed [S:0]       b_dx_reg;
    logic signed [S:0]       b_dx_next;
    logic signed [OW:0]      b_dy_reg;
    logic signed [OW:0]      b_dy_next;
    logic signed [S:0]       b_den_reg;
    logic signed [S:0]       b_den_next;
    logic signed [OW-1:0]    b_lo_reg;
    logic signed [OW-1:0]    b_lo_next;

    logic signed [S:0]       s_sx;
    logic signed [S:0]       ctr_sx;
    logic signed [S:0]       min_sx;
    logic signed [S:0]       max_sx;
    logic signed [S:0]       diff;
    logic [S:0]              absd;
    logic                    below;
    logic                    dz;
    logic                    fault;
    logic signed [S:0]       lo_in;
    logic signed [S:0]       hi_in;
    logic signed [S:0]       x;
    logic signed [OW-1:0]    lo_out;
    logic signed [OW-1:0]    hi_out;
    logic signed [S+17:0]    prod_full;

    assign en       = !b_valid_reg || push_ready;
    assign in_ready = en;

    // Axes without a calibration register of their own fall back to axis 0.
    always_comb
    begin
        idx     = (int'(in_axis) < CAL_N) ? CAL_IDX_W'(in_axis) : '0;
        cal_sel = cal_bus[idx*jacm_pkg::CAL_W +: jacm_pkg::CAL_W];
        cal_ext = EXT_W'(cal_sel);
    end

    always_comb
    begin
        s_sx   = signed'({1'b0, a_s_reg});
        ctr_sx = signed'({1'b0, a_ctr_reg});
        min_sx = signed'({1'b0, a_min_reg});
        max_sx = signed'({1'b0, a_max_reg});
        diff   = s_sx - ctr_sx;
        absd   = diff[S] ? unsigned'(-diff) : unsigned'(diff);
        dz     = CMP_W'(absd) < CMP_W'(dead_band);
        below  = diff[S];
        lo_in  = below ? min_sx : ctr_sx;
        hi_in  = below ? ctr_sx : max_sx;
        lo_out = below ? out_min : out_center;
        hi_out = below ? out_center : out_max;
        fault  = !dz && (hi_in == lo_in);
        // Low bound is tested first so an inverted calibration behaves the same way.
        if (s_sx < lo_in)
            x = lo_in;
        else if (s_sx > hi_in)
            x = hi_in;
        else
            x = s_sx;

        b_flags_next.in_dead_band = dz;
        b_flags_next.cal_fault    = fault;
        // Dead band and empty half-range both reduce to 0 / 1 + out_center.
        if (dz || fault)
        begin
            b_dx_next  = '0;
            b_dy_next  = '0;
            b_den_next = (S+1)'(1);
            b_lo_next  = out_center;
        end
        else
        begin
            b_dx_next  = x - lo_in;
            b_dy_next  = {hi_out[OW-1], hi_out} - {lo_out[OW-1], lo_out};
            b_den_next = hi_in - lo_in;
            b_lo_next  = lo_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_axis_reg  <= in_axis;
            a_s_reg     <= in_sample;
            a_min_reg   <= cal_ext[0 +: S];
            a_ctr_reg   <= cal_ext[S +: S];
            a_max_reg   <= cal_ext[2*S +: S];
            b_axis_reg  <= a_axis_reg;
            b_flags_reg <= b_flags_next;
            b_dx_reg    <= b_dx_next;
            b_dy_reg    <= b_dy_next;
            b_den_reg   <= b_den_next;
            b_lo_reg    <= b_lo_next;
        end
    end

    // The product is registered by the queue entry it is written into.
    assign prod_full  = (S+18)'(b_dx_reg) * (S+18)'(b_dy_reg);
    assign push_valid = b_valid_reg;
    assign push_data  = {b_flags_reg, b_axis_reg, b_lo_reg, b_den_reg, prod_full[PW-1:0]};

endmodule

>>> rtl/jacm_fifo.sv
// ----------------------------------------------------------------------------
// jacm_fifo: short request queue between front and back end
// A few entries of register storage with a fill count.
// ----------------------------------------------------------------------------
module jacm_fifo #(
    parameter int W = 62
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    localparam int DEPTH = jacm_pkg::Q_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/jacm_back.sv
// ----------------------------------------------------------------------------
// jacm_back: pipelined divide, offset and output clamp
// Restoring division with one quotient bit per stage, then the output offset
// and the final clamp into the output register.
// ----------------------------------------------------------------------------
module jacm_back #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2*SAMPLE_BITS+37:0]         in_data,
    input  logic signed [jacm_pkg::OUT_W-1:0] out_min,
    input  logic signed [jacm_pkg::OUT_W-1:0] out_max,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [jacm_pkg::AXIS_W-1:0]       out_axis,
    output logic signed [jacm_pkg::OUT_W-1:0] out_mapped,
    output jacm_pkg::flags_t                  out_flags
);

    localparam int S  = SAMPLE_BITS;
    localparam int NB = S + 16;
    localparam int PW = S + 17;
    localparam int VW = NB + 2;
    localparam int OW = jacm_pkg::OUT_W;
    localparam int AW = jacm_pkg::AXIS_W;

    logic                 en;
    logic signed [PW-1:0] prod;
    logic signed [S:0]    den;
    logic signed [OW-1:0] lo_in;
    logic [AW-1:0]        axis_in;
    jacm_pkg::flags_t     flags_in;
    logic [PW-1:0]        prod_abs;
    logic [S:0]           den_abs;

    logic                 vld_reg   [NB+1];
    logic [NB-1:0]        nq_reg    [NB+1];
    logic [S-1:0]         rem_reg   [NB+1];
    logic [S-1:0]         d_reg     [NB+1];
    logic                 neg_reg   [NB+1];
    logic signed [OW-1:0] lo_reg    [NB+1];
    logic [AW-1:0]        ax_reg    [NB+1];
    jacm_pkg::flags_t     fl_reg    [NB+1];
    logic [NB-1:0]        nq_next   [1:NB];
    logic [S-1:0]         rem_next  [1:NB];

    logic                 f_valid_reg;
    logic signed [VW-1:0] f_v_reg;
    logic signed [VW-1:0] f_v_next;
    logic [AW-1:0]        f_axis_reg;
    jacm_pkg::flags_t     f_flags_reg;
    logic signed [NB:0]   q_pos;
    logic signed [NB:0]   q_s;

    logic                 out_valid_reg;
    logic [AW-1:0]        out_axis_reg;
    logic signed [OW-1:0] out_mapped_reg;
    logic signed [OW-1:0] out_mapped_next;
    jacm_pkg::flags_t     out_flags_reg;

    // The whole pipeline moves together and holds while a result waits.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign prod     = in_data[PW-1:0];
    assign den      = in_data[PW +: S+1];
    assign lo_in    = in_data[PW+S+1 +: OW];
    assign axis_in  = in_data[PW+S+1+OW +: AW];
    assign flags_in = in_data[PW+S+1+OW+AW +: 2];
    assign prod_abs = prod[PW-1] ? unsigned'(-prod) : unsigned'(prod);
    assign den_abs  = den[S] ? unsigned'(-den) : unsigned'(den);

    // The divide works on magnitudes; the sign is put back so it truncates toward zero.
    for (genvar i = 1; i <= NB; i++)
    begin : g_step
        logic [S:0] t;
        logic [S:0] t_sub;
        logic       ge;
        assign t           = {rem_reg[i-1], nq_reg[i-1][NB-1]};
        assign t_sub       = t - {1'b0, d_reg[i-1]};
        assign ge          = t >= {1'b0, d_reg[i-1]};
        assign rem_next[i] = ge ? t_sub[S-1:0] : t[S-1:0];
        assign nq_next[i]  = {nq_reg[i-1][NB-2:0], ge};
    end

    always_comb
    begin
        q_pos    = signed'({1'b0, nq_reg[NB]});
        q_s      = neg_reg[NB] ? -q_pos : q_pos;
        f_v_next = VW'(q_s) + VW'(lo_reg[NB]);
        if (f_v_reg < VW'(out_min))
            out_mapped_next = out_min;
        else if (f_v_reg > VW'(out_max))
            out_mapped_next = out_max;
        else
            out_mapped_next = f_v_reg[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NB; i++)
                vld_reg[i] <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= NB; i++)
                vld_reg[i] <= vld_reg[i-1];
            f_valid_reg   <= vld_reg[NB];
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg[0]  <= prod_abs[NB-1:0];
            rem_reg[0] <= '0;
            d_reg[0]   <= den_abs[S-1:0];
            neg_reg[0] <= prod[PW-1] ^ den[S];
            lo_reg[0]  <= lo_in;
            ax_reg[0]  <= axis_in;
            fl_reg[0]  <= flags_in;
            for (int i = 1; i <= NB; i++)
            begin
                nq_reg[i]  <= nq_next[i];
                rem_reg[i] <= rem_next[i];
                d_reg[i]   <= d_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                lo_reg[i]  <= lo_reg[i-1];
                ax_reg[i]  <= ax_reg[i-1];
                fl_reg[i]  <= fl_reg[i-1];
            end
            f_v_reg        <= f_v_next;
            f_axis_reg     <= ax_reg[NB];
            f_flags_reg    <= fl_reg[NB];
            out_mapped_reg <= out_mapped_next;
            out_axis_reg   <= f_axis_reg;
            out_flags_reg  <= f_flags_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_axis   = out_axis_reg;
    assign out_mapped = out_mapped_reg;
    assign out_flags  = out_flags_reg;

endmodule

>>> rtl/joystick_axis_calibrated_map.sv
// ----------------------------------------------------------------------------
// joystick_axis_calibrated_map: calibrated joystick axis map with dead band
// Maps raw axis samples through per-axis min/center/max calibration onto a
// programmable output scale, with a dead band around center.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while s_axis_tready is high and returns
// one result per sample, in order. A result is registered through the two
// front stages, the queue, the divider stages and the offset and clamp stages;
// most of that path is the divider, which resolves one quotient bit per
// pipeline stage. Two front stages and a four-entry queue sit ahead of the
// divider, so samples are still taken while a finished result waits on the
// output. Configuration writes are taken every cycle and should only be issued
// while no sample is in flight.
module joystick_axis_calibrated_map #(
    parameter int SAMPLE_BITS = 12,
    parameter int AXES        = 4
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // s_axis_tdata fields from bit 0: axis, sample, zero fill
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+2+7)/8)*8-1:0]    s_axis_tdata,
    // m_axis_tdata fields from bit 0: axis_out, mapped, zero fill
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [jacm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // m_axis_tuser fields from bit 0: in_dead_band, cal_fault
    output logic [1:0]                            m_axis_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [jacm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jacm_pkg::CAL_W-1:0]            cfg_data
);

    localparam int S         = SAMPLE_BITS;
    localparam int CAL_N     = (AXES < jacm_pkg::CAL_REGS) ? AXES : jacm_pkg::CAL_REGS;
    localparam int CAL_IDX_W = (CAL_N > 1) ? $clog2(CAL_N) : 1;
    localparam int EW        = 2*S + 38;
    localparam int OW        = jacm_pkg::OUT_W;
    localparam int AW        = jacm_pkg::AXIS_W;
    localparam int PAD_W     = jacm_pkg::OUT_TDATA_W - AW - OW;

    logic [jacm_pkg::CAL_W-1:0]  cal_reg [CAL_N];
    logic [jacm_pkg::DB_W-1:0]   dead_band_reg;
    logic signed [OW-1:0]        out_min_reg;
    logic signed [OW-1:0]        out_center_reg;
    logic signed [OW-1:0]        out_max_reg;
    logic [CAL_N*jacm_pkg::CAL_W-1:0] cal_bus;

    logic                        push_valid;
    logic                        push_ready;
    logic [EW-1:0]               push_data;
    logic                        pop_valid;
    logic                        pop_ready;
    logic [EW-1:0]               pop_data;
    logic [AW-1:0]               axis_out;
    logic signed [OW-1:0]        mapped;
    jacm_pkg::flags_t            flags;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAL_N; i++)
                cal_reg[i] <= jacm_pkg::CAL_RESET;
            dead_band_reg  <= jacm_pkg::DEAD_BAND_RESET;
            out_min_reg    <= jacm_pkg::OUT_MIN_RESET;
            out_center_reg <= jacm_pkg::OUT_CENTER_RESET;
            out_max_reg    <= jacm_pkg::OUT_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            case (jacm_pkg::reg_idx_t'(cfg_index))
                jacm_pkg::REG_CAL_LEFT_X, jacm_pkg::REG_CAL_LEFT_Y,
                jacm_pkg::REG_CAL_RIGHT_X, jacm_pkg::REG_CAL_RIGHT_Y:
                begin
                    // Calibration of an axis the block does not serve is dropped.
                    if (int'(cfg_index) < CAL_N)
                        cal_reg[cfg_index[CAL_IDX_W-1:0]] <= cfg_data;
                end
                jacm_pkg::REG_DEAD_BAND:  dead_band_reg  <= cfg_data[jacm_pkg::DB_W-1:0];
                jacm_pkg::REG_OUT_MIN:    out_min_reg    <= cfg_data[OW-1:0];
                jacm_pkg::REG_OUT_CENTER: out_center_reg <= cfg_data[OW-1:0];
                jacm_pkg::REG_OUT_MAX:    out_max_reg    <= cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    for (genvar g = 0; g < CAL_N; g++)
    begin : g_cal
        assign cal_bus[g*jacm_pkg::CAL_W +: jacm_pkg::CAL_W] = cal_reg[g];
    end

    jacm_front #(
        .SAMPLE_BITS (S),
        .CAL_N       (CAL_N)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_axis    (s_axis_tdata[AW-1:0]),
        .in_sample  (s_axis_tdata[AW +: S]),
        .cal_bus    (cal_bus),
        .dead_band  (dead_band_reg),
        .out_min    (out_min_reg),
        .out_center (out_center_reg),
        .out_max    (out_max_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    jacm_fifo #(
        .W (EW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    jacm_back #(
        .SAMPLE_BITS (S)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (pop_valid),
        .in_ready   (pop_ready),
        .in_data    (pop_data),
        .out_min    (out_min_reg),
        .out_max    (out_max_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_axis   (axis_out),
        .out_mapped (mapped),
        .out_flags  (flags)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, mapped, axis_out};
    assign m_axis_tuser = flags;

    // A sample is either in the dead band or on an empty half-range, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("dead band and calibration fault raised together");

    // Dead band and fault results carry the output center when it lies in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1]) &&
        (out_min_reg <= out_center_reg) && (out_center_reg <= out_max_reg)
        |-> mapped == out_center_reg)
        else $error("flagged result is not the output center");

    // With an ordered output scale every result lies inside it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (out_min_reg <= out_max_reg)
        |-> (mapped >= out_min_reg) && (mapped <= out_max_reg))
        else $error("mapped value outside the output scale");

endmodule
